### rtl/intercept_firing_solution_defines.svh
// assertion macros for the intercept firing solution block
`ifndef INTERCEPT_FIRING_SOLUTION_DEFINES_SVH
`define INTERCEPT_FIRING_SOLUTION_DEFINES_SVH
`ifndef SYNTHESIS
`define IFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ifs assertion failed");
`define IFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ifs assertion failed");
`else
`define IFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ifs_pkg.sv
`default_nettype none
package ifs_pkg;
	localparam int COORD_W = 32;
	localparam int MUZ_W = 31;
	localparam int TIME_W = 32;
	localparam int TFRAC = 16;
	localparam int DEG_SH = 30;
	localparam int DEG_MIN = 65536;
	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;
	localparam int XW = ((PW > 2 * MUZ_W) ? PW : 2 * MUZ_W) + 3;
	localparam int LO = XW / 2;
	localparam int HI = XW - LO;
	localparam int NW = XW + 2;
	localparam int PLEN = DW + TIME_W + 1;
	localparam int LW = PLEN - TFRAC + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] shooter_pos_x;
		logic signed [COORD_W-1:0] shooter_pos_y;
		logic signed [COORD_W-1:0] shooter_pos_z;
		logic signed [COORD_W-1:0] shooter_vel_x;
		logic signed [COORD_W-1:0] shooter_vel_y;
		logic signed [COORD_W-1:0] shooter_vel_z;
		logic signed [COORD_W-1:0] target_pos_x;
		logic signed [COORD_W-1:0] target_pos_y;
		logic signed [COORD_W-1:0] target_pos_z;
		logic signed [COORD_W-1:0] target_vel_x;
		logic signed [COORD_W-1:0] target_vel_y;
		logic signed [COORD_W-1:0] target_vel_z;
	} geo_t;

	typedef struct packed {
		logic                      solution_valid;
		logic [TIME_W-1:0]         impact_time;
		logic signed [COORD_W-1:0] lead_x;
		logic signed [COORD_W-1:0] lead_y;
		logic signed [COORD_W-1:0] lead_z;
	} sol_t;

	typedef struct packed {
		logic signed [DW-1:0]      ux;
		logic signed [DW-1:0]      uy;
		logic signed [DW-1:0]      uz;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
		logic signed [COORD_W-1:0] tz;
	} kin_t;

	typedef struct packed {
		kin_t                 kin;
		logic                 mz;
		logic                 deg;
		logic                 a_neg;
		logic                 h_neg;
		logic                 cz;
		logic                 dneg;
		logic signed [XW-1:0] h;
		logic [XW-1:0]        absa;
		logic [XW-1:0]        absh;
		logic [XW-1:0]        c;
	} ctl_t;

	typedef struct packed {
		kin_t kin;
		logic mz;
		logic oka;
	} dpl_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [LW-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[LW-1:COORD_W-1] == '0 || v[LW-1:COORD_W-1] == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[LW-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/intercept_firing_solution.sv
// intercept firing solution
// geo channel: geo_valid / geo_stall carry one item of shooter and target
// position and velocity (signed Q24.8); an item is taken at a clock edge with
// geo_valid high and geo_stall low.
// sol channel: sol_valid / sol_stall carry one result item per input item, in
// order: solution_valid, impact_time (unsigned Q16.16) and the lead point.
// muzzle_we / muzzle_wdata write the muzzle speed (unsigned Q23.8); write it only while
// no item is in flight.
// the pipeline from acceptance to sol_valid: 7 front stages for
// products, sums and the discriminant, 69 stages of the bit-per-stage square
// root, one stage for the root choice, 32 stages of the bit-per-stage
// dividers, two stages for the lead point and the output register.
// throughput is one item per cycle while geo_stall is low.
// while the output item waits under sol_stall, empty stages still close up
// and new items are taken until the item in front of the output register is
// valid; then geo_stall rises and the whole pipeline holds.
// arst_n clears the pipeline valid bits, sol_valid and the muzzle speed.
`default_nettype none
`include "intercept_firing_solution_defines.svh"
module intercept_firing_solution import ifs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             geo_valid,
	output logic                  geo_stall,
	input  wire geo_t             geo,
	output logic                  sol_valid,
	input  wire logic             sol_stall,
	output sol_t                  sol,
	input  wire logic             muzzle_we,
	input  wire logic [MUZ_W-1:0] muzzle_wdata
);
	logic [MUZ_W-1:0] muz_q;
	logic             sol_valid_q;
	sol_t             sol_q;
	logic             en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic signed [DW-1:0]   d_s1 [3];
	kin_t                   kin_s1, kin_s2, kin_s3, kin_s9, kin_s10;
	logic signed [PW-1:0]   uup_s2 [3];
	logic signed [PW-1:0]   hp_s2  [3];
	logic signed [PW-1:0]   cp_s2  [3];
	logic [2*MUZ_W-1:0]     m2_s2, m2_s3;
	logic                   mz_s2, mz_s3;
	logic signed [XW-1:0]   a_s3, h_s3, c_s3;
	ctl_t                   ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_sq;
	logic [2*LO-1:0]        hll_s5, all_s5;
	logic [LO+HI-1:0]       hlh_s5, alh_s5, ahl_s5;
	logic [2*HI-1:0]        hhh_s5, ahh_s5;
	logic [2*XW-1:0]        hh_s6, ac_s6, rad_s7;
	logic                   v_sq;
	logic [XW-1:0]          root_sq;
	logic [NW-1:0]          num1_s8, den1_s8, num2_s8, den2_s8;
	dpl_t                   dpl_s8, dpl_d;
	logic                   ok2_s8, ok2_d;
	logic                   v_d1, v_d2;
	logic [TIME_W-1:0]      t1_d, t2_d, t_s9, t_s10;
	logic                   fnd_s9, fnd_s10;
	logic signed [PLEN-1:0] p_s10 [3];

	assign en        = !(sol_valid_q && sol_stall && v_s10);
	assign geo_stall = !en;
	assign sol_valid = sol_valid_q;
	assign sol       = sol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muz_q <= '0;
		end else if (muzzle_we) begin
			muz_q <= muzzle_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= geo_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_sq;
			v_s9  <= v_d1;
			v_s10 <= v_s9;
		end
	end

	// relative geometry, products, dot products
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]   <= DW'(geo.target_pos_x) - DW'(geo.shooter_pos_x);
			d_s1[1]   <= DW'(geo.target_pos_y) - DW'(geo.shooter_pos_y);
			d_s1[2]   <= DW'(geo.target_pos_z) - DW'(geo.shooter_pos_z);
			kin_s1.ux <= DW'(geo.target_vel_x) - DW'(geo.shooter_vel_x);
			kin_s1.uy <= DW'(geo.target_vel_y) - DW'(geo.shooter_vel_y);
			kin_s1.uz <= DW'(geo.target_vel_z) - DW'(geo.shooter_vel_z);
			kin_s1.tx <= geo.target_pos_x;
			kin_s1.ty <= geo.target_pos_y;
			kin_s1.tz <= geo.target_pos_z;

			uup_s2[0] <= PW'(kin_s1.ux) * PW'(kin_s1.ux);
			uup_s2[1] <= PW'(kin_s1.uy) * PW'(kin_s1.uy);
			uup_s2[2] <= PW'(kin_s1.uz) * PW'(kin_s1.uz);
			hp_s2[0]  <= PW'(d_s1[0]) * PW'(kin_s1.ux);
			hp_s2[1]  <= PW'(d_s1[1]) * PW'(kin_s1.uy);
			hp_s2[2]  <= PW'(d_s1[2]) * PW'(kin_s1.uz);
			cp_s2[0]  <= PW'(d_s1[0]) * PW'(d_s1[0]);
			cp_s2[1]  <= PW'(d_s1[1]) * PW'(d_s1[1]);
			cp_s2[2]  <= PW'(d_s1[2]) * PW'(d_s1[2]);
			m2_s2     <= (2*MUZ_W)'(muz_q) * (2*MUZ_W)'(muz_q);
			mz_s2     <= muz_q == '0;
			kin_s2    <= kin_s1;

			a_s3   <= XW'(uup_s2[0]) + XW'(uup_s2[1]) + XW'(uup_s2[2])
				- $signed(XW'(m2_s2));
			h_s3   <= XW'(hp_s2[0]) + XW'(hp_s2[1]) + XW'(hp_s2[2]);
			c_s3   <= XW'(cp_s2[0]) + XW'(cp_s2[1]) + XW'(cp_s2[2]);
			m2_s3  <= m2_s2;
			mz_s3  <= mz_s2;
			kin_s3 <= kin_s2;
		end
	end

	// magnitudes and the near-linear test
	logic [XW-1:0]       absa_c, absh_c;
	logic [2*MUZ_W-1:0]  thr_c;
	assign absa_c = a_s3[XW-1] ? XW'(-a_s3) : XW'(a_s3);
	assign absh_c = h_s3[XW-1] ? XW'(-h_s3) : XW'(h_s3);
	assign thr_c  = (m2_s3 > (2*MUZ_W)'(DEG_MIN)) ? m2_s3 : (2*MUZ_W)'(DEG_MIN);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4.kin   <= kin_s3;
			ctl_s4.mz    <= mz_s3;
			ctl_s4.deg   <= ((XW+DEG_SH)'(absa_c) << DEG_SH) < (XW+DEG_SH)'(thr_c);
			ctl_s4.a_neg <= a_s3[XW-1];
			ctl_s4.h_neg <= h_s3[XW-1];
			ctl_s4.cz    <= c_s3 == '0;
			ctl_s4.dneg  <= 1'b0;
			ctl_s4.h     <= h_s3;
			ctl_s4.absa  <= absa_c;
			ctl_s4.absh  <= absh_c;
			ctl_s4.c     <= XW'(c_s3);

			// split products for h*h and |a|*c
			hll_s5 <= (2*LO)'(ctl_s4.absh[LO-1:0]) * (2*LO)'(ctl_s4.absh[LO-1:0]);
			hlh_s5 <= (LO+HI)'(ctl_s4.absh[LO-1:0]) * (LO+HI)'(ctl_s4.absh[XW-1:LO]);
			hhh_s5 <= (2*HI)'(ctl_s4.absh[XW-1:LO]) * (2*HI)'(ctl_s4.absh[XW-1:LO]);
			all_s5 <= (2*LO)'(ctl_s4.absa[LO-1:0]) * (2*LO)'(ctl_s4.c[LO-1:0]);
			alh_s5 <= (LO+HI)'(ctl_s4.absa[LO-1:0]) * (LO+HI)'(ctl_s4.c[XW-1:LO]);
			ahl_s5 <= (LO+HI)'(ctl_s4.absa[XW-1:LO]) * (LO+HI)'(ctl_s4.c[LO-1:0]);
			ahh_s5 <= (2*HI)'(ctl_s4.absa[XW-1:LO]) * (2*HI)'(ctl_s4.c[XW-1:LO]);
			ctl_s5 <= ctl_s4;

			hh_s6  <= ((2*XW)'(hhh_s5) << (2*LO)) + ((2*XW)'(hlh_s5) << (LO + 1))
				+ (2*XW)'(hll_s5);
			ac_s6  <= ((2*XW)'(ahh_s5) << (2*LO))
				+ (((2*XW)'(alh_s5) + (2*XW)'(ahl_s5)) << LO) + (2*XW)'(all_s5);
			ctl_s6 <= ctl_s5;
		end
	end

	// discriminant
	logic signed [2*XW:0] disc_c;
	ctl_t                 ctl_c7;
	assign disc_c = ctl_s6.a_neg ? $signed({1'b0, hh_s6}) + $signed({1'b0, ac_s6})
		: $signed({1'b0, hh_s6}) - $signed({1'b0, ac_s6});

	always_comb begin
		ctl_c7      = ctl_s6;
		ctl_c7.dneg = disc_c[2*XW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s7 <= disc_c[2*XW] ? '0 : disc_c[2*XW-1:0];
			ctl_s7 <= ctl_c7;
		end
	end

	ifs_sqrt #(
		.RW  (2 * XW),
		.PLW ($bits(ctl_t))
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s7),
		.rad    (rad_s7),
		.pl_in  (ctl_s7),
		.out_v  (v_sq),
		.root   (root_sq),
		.pl_out (ctl_sq)
	);

	// root choice inputs
	logic signed [NW-1:0] q_c;
	logic [NW-1:0]        absq_c;
	logic                 qz_c, ok1_c, ok2_c, okl_c;
	assign q_c = ctl_sq.h_neg ? $signed({2'b00, root_sq}) - NW'(ctl_sq.h)
		: -(NW'(ctl_sq.h) + $signed({2'b00, root_sq}));
	assign absq_c = q_c[NW-1] ? NW'(-q_c) : NW'(q_c);
	assign qz_c   = q_c == '0;
	assign ok1_c  = !ctl_sq.deg && !ctl_sq.dneg && !qz_c && (q_c[NW-1] == ctl_sq.a_neg);
	assign ok2_c  = !ctl_sq.deg && !ctl_sq.dneg && !qz_c && !q_c[NW-1] && !ctl_sq.cz;
	assign okl_c  = ctl_sq.deg && ctl_sq.h_neg && !ctl_sq.cz;

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s8    <= ctl_sq.deg ? NW'(ctl_sq.c) : absq_c;
			den1_s8    <= ctl_sq.deg ? (NW'(ctl_sq.absh) << 1) : NW'(ctl_sq.absa);
			num2_s8    <= NW'(ctl_sq.c);
			den2_s8    <= absq_c;
			dpl_s8.kin <= ctl_sq.kin;
			dpl_s8.mz  <= ctl_sq.mz;
			dpl_s8.oka <= ctl_sq.deg ? okl_c : ok1_c;
			ok2_s8     <= ok2_c;
		end
	end

	ifs_div #(
		.DNW (NW),
		.PLW ($bits(dpl_t))
	) u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s8),
		.num    (num1_s8),
		.den    (den1_s8),
		.pl_in  (dpl_s8),
		.out_v  (v_d1),
		.quo    (t1_d),
		.pl_out (dpl_d)
	);

	ifs_div #(
		.DNW (NW),
		.PLW (1)
	) u_div2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s8),
		.num    (num2_s8),
		.den    (den2_s8),
		.pl_in  (ok2_s8),
		.out_v  (v_d2),
		.quo    (t2_d),
		.pl_out (ok2_d)
	);

	// smallest positive root, then lead point
	logic take2_c;
	assign take2_c = ok2_d && (!dpl_d.oka || t2_d < t1_d);

	logic signed [LW-1:0] lx_c, ly_c, lz_c;
	assign lx_c = LW'(kin_s10.tx) + LW'(p_s10[0] >>> TFRAC);
	assign ly_c = LW'(kin_s10.ty) + LW'(p_s10[1] >>> TFRAC);
	assign lz_c = LW'(kin_s10.tz) + LW'(p_s10[2] >>> TFRAC);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9   <= take2_c ? t2_d : (dpl_d.oka ? t1_d : '0);
			fnd_s9 <= (dpl_d.oka || ok2_d) && !dpl_d.mz;
			kin_s9 <= dpl_d.kin;

			p_s10[0] <= PLEN'(kin_s9.ux) * $signed(PLEN'({1'b0, t_s9}));
			p_s10[1] <= PLEN'(kin_s9.uy) * $signed(PLEN'({1'b0, t_s9}));
			p_s10[2] <= PLEN'(kin_s9.uz) * $signed(PLEN'({1'b0, t_s9}));
			t_s10    <= t_s9;
			fnd_s10  <= fnd_s9;
			kin_s10  <= kin_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sol_valid_q <= 1'b0;
		end else if (!sol_valid_q || !sol_stall) begin
			sol_valid_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (!sol_valid_q || !sol_stall) begin
			if (fnd_s10) begin
				sol_q.solution_valid <= 1'b1;
				sol_q.impact_time    <= t_s10;
				sol_q.lead_x         <= sat_coord(lx_c);
				sol_q.lead_y         <= sat_coord(ly_c);
				sol_q.lead_z         <= sat_coord(lz_c);
			end else begin
				sol_q <= '0;
			end
		end
	end

	`IFS_ASSERT_IMPL(a_invalid_zero, clk, arst_n, sol_valid && !sol.solution_valid, sol == '0)
	`IFS_ASSERT_IMPL(a_div_aligned, clk, arst_n, 1'b1, v_d1 == v_d2)
	`IFS_ASSERT_IMPL(a_muzzle_set, clk, arst_n, sol_valid && sol.solution_valid, muz_q != '0)
endmodule
`default_nettype wire

### rtl/ifs_sqrt.sv
`default_nettype none
module ifs_sqrt import ifs_pkg::*; #(
	parameter int RW = 2 * XW,
	parameter int PLW = $bits(ctl_t)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire logic [RW-1:0]  rad,
	input  wire logic [PLW-1:0] pl_in,
	output logic                out_v,
	output logic [RW/2-1:0]     root,
	output logic [PLW-1:0]      pl_out
);
	localparam int N = RW / 2;

	logic [RW-1:0]  rem_s [N+1];
	logic [N-1:0]   rt_s  [N+1];
	logic           v_s   [N+1];
	logic [PLW-1:0] pl_s  [N+1];

	assign rem_s[0] = rad;
	assign rt_s[0]  = '0;
	assign v_s[0]   = in_v;
	assign pl_s[0]  = pl_in;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int I = N - 1 - k;
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = (RW'(rt_s[k]) << (I + 1)) | (RW'(1) << (2 * I));
		assign ge = rem_s[k] >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
				rt_s[k+1]  <= ge ? (rt_s[k] | (N'(1) << I)) : rt_s[k];
				pl_s[k+1]  <= pl_s[k];
			end
		end
	end

	assign out_v  = v_s[N];
	assign root   = rt_s[N];
	assign pl_out = pl_s[N];
endmodule
`default_nettype wire

### rtl/ifs_div.sv
`default_nettype none
module ifs_div import ifs_pkg::*; #(
	parameter int DNW = NW,
	parameter int PLW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire logic [DNW-1:0] num,
	input  wire logic [DNW-1:0] den,
	input  wire logic [PLW-1:0] pl_in,
	output logic                out_v,
	output logic [TIME_W-1:0]   quo,
	output logic [PLW-1:0]      pl_out
);
	localparam int RWD = DNW + TIME_W;

	logic [RWD-1:0]    rem_s [TIME_W+1];
	logic [DNW-1:0]    den_s [TIME_W+1];
	logic [TIME_W-1:0] q_s   [TIME_W+1];
	logic              sat_s [TIME_W+1];
	logic              v_s   [TIME_W+1];
	logic [PLW-1:0]    pl_s  [TIME_W+1];

	assign rem_s[0] = RWD'(num) << TFRAC;
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign sat_s[0] = RWD'(num) >= (RWD'(den) << TFRAC);
	assign v_s[0]   = in_v;
	assign pl_s[0]  = pl_in;

	for (genvar k = 0; k < TIME_W; k++) begin : g_step
		localparam int I = TIME_W - 1 - k;
		logic [RWD-1:0] sh;
		logic           ge;
		assign sh = RWD'(den_s[k]) << I;
		assign ge = rem_s[k] >= sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - sh : rem_s[k];
				q_s[k+1]   <= ge ? (q_s[k] | (TIME_W'(1) << I)) : q_s[k];
				den_s[k+1] <= den_s[k];
				sat_s[k+1] <= sat_s[k];
				pl_s[k+1]  <= pl_s[k];
			end
		end
	end

	assign out_v  = v_s[TIME_W];
	assign quo    = sat_s[TIME_W] ? '1 : q_s[TIME_W];
	assign pl_out = pl_s[TIME_W];
endmodule
`default_nettype wire

### tb/intercept_firing_solution_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module intercept_firing_solution_tb import ifs_pkg::*;;
	typedef logic signed [255:0] wide_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [MUZ_W-1:0] MUZ_300 = MUZ_W'(300 * 256);

	logic clk;
	logic arst_n;
	logic geo_valid;
	logic geo_stall;
	geo_t geo;
	logic sol_valid;
	logic sol_stall;
	sol_t sol;
	logic muzzle_we;
	logic [MUZ_W-1:0] muzzle_wdata;

	logic [MUZ_W-1:0] muzzle_model;
	sol_t pending_solutions[$];
	int mismatches;
	int quiet_cycles;
	int hold_cycles;
	bit tx_idle_on;
	bit rx_idle_on;

	intercept_firing_solution dut (
		.clk(clk),
		.arst_n(arst_n),
		.geo_valid(geo_valid),
		.geo_stall(geo_stall),
		.geo(geo),
		.sol_valid(sol_valid),
		.sol_stall(sol_stall),
		.sol(sol),
		.muzzle_we(muzzle_we),
		.muzzle_wdata(muzzle_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] time_q16(input logic [255:0] num, input logic [255:0] den);
		logic [255:0] q;
		q = (num << 16) / den;
		return (q > 256'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
	endfunction

	function automatic logic [255:0] floor_sqrt(input logic [255:0] x);
		logic [255:0] res;
		logic [255:0] bt;
		res = '0;
		bt = 256'd1 << 254;
		while (bt != 0 && bt > x) bt = bt >> 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x = x - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp_coord(input wide_t v);
		if (v > wide_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
		if (v < wide_t'(32'sh80000000)) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic sol_t solve_intercept(input geo_t g, input logic [MUZ_W-1:0] muz);
		wide_t d[3];
		wide_t u[3];
		wide_t tp[3];
		wide_t uu, h, c, a, absa, thr, disc, s, q, absq, m, m2, tw, p;
		logic [31:0] t, t1, t2;
		bit found, ok1, ok2;
		sol_t r;
		r = '0;
		tp[0] = g.target_pos_x;
		tp[1] = g.target_pos_y;
		tp[2] = g.target_pos_z;
		d[0] = wide_t'(g.target_pos_x) - wide_t'(g.shooter_pos_x);
		d[1] = wide_t'(g.target_pos_y) - wide_t'(g.shooter_pos_y);
		d[2] = wide_t'(g.target_pos_z) - wide_t'(g.shooter_pos_z);
		u[0] = wide_t'(g.target_vel_x) - wide_t'(g.shooter_vel_x);
		u[1] = wide_t'(g.target_vel_y) - wide_t'(g.shooter_vel_y);
		u[2] = wide_t'(g.target_vel_z) - wide_t'(g.shooter_vel_z);
		if (muz == 0) return r;
		uu = 0;
		h = 0;
		c = 0;
		for (int i = 0; i < 3; i++) begin
			uu = uu + u[i] * u[i];
			h = h + d[i] * u[i];
			c = c + d[i] * d[i];
		end
		m = muz;
		m2 = m * m;
		a = uu - m2;
		absa = (a < 0) ? -a : a;
		thr = (m2 > 65536) ? m2 : 65536;
		found = 0;
		t = '0;
		if ((absa <<< 30) < thr) begin
			if (h < 0 && c != 0) begin
				t = time_q16(c, (-h) <<< 1);
				found = 1;
			end
		end else begin
			disc = h * h - a * c;
			if (disc >= 0) begin
				s = floor_sqrt(disc);
				q = (h < 0) ? s - h : -(h + s);
				if (q != 0) begin
					absq = (q < 0) ? -q : q;
					ok1 = ((q < 0) == (a < 0));
					ok2 = (q > 0) && (c != 0);
					t1 = ok1 ? time_q16(absq, absa) : '0;
					t2 = ok2 ? time_q16(c, q) : '0;
					if (ok1) begin
						t = t1;
						found = 1;
					end
					if (ok2 && (!ok1 || t2 < t1)) begin
						t = t2;
						found = 1;
					end
				end
			end
		end
		if (!found) return r;
		r.solution_valid = 1'b1;
		r.impact_time = t;
		tw = t;
		p = (u[0] * tw) >>> 16;
		r.lead_x = clamp_coord(tp[0] + p);
		p = (u[1] * tw) >>> 16;
		r.lead_y = clamp_coord(tp[1] + p);
		p = (u[2] * tw) >>> 16;
		r.lead_z = clamp_coord(tp[2] + p);
		return r;
	endfunction

	// shooter at rest at origin, target given in meters and m/s
	function automatic geo_t relative_geo(input int px, input int py, input int pz,
			input int vx, input int vy, input int vz);
		geo_t g;
		g = '0;
		g.target_pos_x = px * 256;
		g.target_pos_y = py * 256;
		g.target_pos_z = pz * 256;
		g.target_vel_x = vx * 256;
		g.target_vel_y = vy * 256;
		g.target_vel_z = vz * 256;
		return g;
	endfunction

	function automatic int rand_span(input int half);
		return int'($urandom_range(2 * half)) - half;
	endfunction

	function automatic geo_t random_geo();
		geo_t g;
		if ($urandom_range(99) < 15) begin
			g = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			g.shooter_pos_x = rand_span(1 << 20);
			g.shooter_pos_y = rand_span(1 << 20);
			g.shooter_pos_z = rand_span(1 << 20);
			g.shooter_vel_x = rand_span(1 << 15);
			g.shooter_vel_y = rand_span(1 << 15);
			g.shooter_vel_z = rand_span(1 << 15);
			g.target_pos_x = rand_span(1 << 22);
			g.target_pos_y = rand_span(1 << 22);
			g.target_pos_z = rand_span(1 << 22);
			g.target_vel_x = rand_span(1 << 17);
			g.target_vel_y = rand_span(1 << 17);
			g.target_vel_z = rand_span(1 << 17);
		end
		return g;
	endfunction

	task automatic send_geo(input geo_t g);
		sol_t want;
		want = solve_intercept(g, muzzle_model);
		while (tx_idle_on && $urandom_range(99) < 8) begin
			@(negedge clk);
			geo_valid <= 1'b0;
		end
		@(negedge clk);
		geo_valid <= 1'b1;
		geo <= g;
		@(posedge clk);
		while (geo_stall) @(posedge clk);
		pending_solutions = {pending_solutions, want};
	endtask

	task automatic stop_sending();
		@(negedge clk);
		geo_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (pending_solutions.size() != 0) @(posedge clk);
	endtask

	task automatic write_muzzle(input logic [MUZ_W-1:0] v);
		@(negedge clk);
		muzzle_we <= 1'b1;
		muzzle_wdata <= v;
		@(negedge clk);
		muzzle_we <= 1'b0;
		muzzle_model = v;
	endtask

	task automatic test_reset_muzzle_zero();
		send_geo(relative_geo(1000, 0, 0, 0, 0, 0));
		send_geo(relative_geo(-500, 200, 30, 10, -5, 1));
		wait_drained();
	endtask

	task automatic test_directed();
		geo_t g;
		write_muzzle(MUZ_300);
		send_geo(relative_geo(1000, 0, 0, 0, 0, 0));
		send_geo(relative_geo(1000, 500, -200, 20, -30, 5));
		send_geo(relative_geo(1000, 0, 0, 400, 0, 0));
		send_geo(relative_geo(-1000, 0, 0, 300, 0, 0));
		send_geo(relative_geo(0, 1000, 0, 300, 0, 0));
		send_geo(relative_geo(1000, 0, 0, 300, 0, 0));
		send_geo(relative_geo(0, 0, 0, 0, 0, 0));
		send_geo(relative_geo(0, 0, 0, 50, 0, 0));
		send_geo(relative_geo(1000, 0, 0, 0, 400, 0));
		send_geo(relative_geo(1000, 0, 0, -400, 0, 0));
		send_geo(relative_geo(1000, 0, 0, -400, 100, 0));
		g = relative_geo(800, -300, 100, 10, 0, 0);
		g.shooter_vel_x = -50 * 256;
		g.shooter_pos_z = 40 * 256;
		send_geo(g);
		send_geo({12{32'h7FFFFFFF}});
		send_geo({12{32'h80000000}});
		g = {12{32'h80000000}};
		g.target_pos_x = 32'h7FFFFFFF;
		g.target_pos_y = 32'h7FFFFFFF;
		g.target_vel_x = 32'h7FFFFFFF;
		g.target_vel_z = 32'h7FFFFFFF;
		send_geo(g);
		g = '0;
		g.target_pos_x = 32'h7FFFFF00;
		g.target_vel_x = 32'h7FFFFFFF;
		g.target_vel_y = 32'h80000000;
		g.shooter_pos_x = 32'h00000100;
		send_geo(g);
		send_geo(relative_geo(0, 0, 1, 0, 0, 0));
		send_geo({12{32'hFFFFFFFF}});
		send_geo({12{32'h00000001}});
		wait_drained();
	endtask

	task automatic test_random_setting(input logic [MUZ_W-1:0] muz, input int count);
		write_muzzle(muz);
		for (int i = 0; i < count; i++) send_geo(random_geo());
		send_geo({12{32'h7FFFFFFF}});
		send_geo({12{32'h80000000}});
		wait_drained();
	endtask

	task automatic test_random();
		test_random_setting(MUZ_W'(1), 200);
		test_random_setting(MUZ_W'(32'h7FFFFFFF), 200);
		test_random_setting(MUZ_300, 350);
		test_random_setting(MUZ_W'($urandom_range(32'h40000, 32'h100)), 250);
		tx_idle_on = 0;
		rx_idle_on = 0;
		test_random_setting(MUZ_W'($urandom), 250);
		tx_idle_on = 1;
		rx_idle_on = 1;
	endtask

	task automatic test_backpressure();
		write_muzzle(MUZ_300);
		hold_cycles = 400;
		for (int i = 0; i < 400; i++) send_geo(random_geo());
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			sol_stall <= 1'b1;
		end else begin
			sol_stall <= rx_idle_on && ($urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		sol_t want;
		if (arst_n && sol_valid && !sol_stall) begin
			if (pending_solutions.size() == 0) begin
				$error("unexpected solution item %h", sol);
				mismatches++;
			end else begin
				want = pending_solutions.pop_front();
				if (sol.solution_valid !== want.solution_valid) begin
					$error("solution_valid exp %0d got %0d", want.solution_valid,
						sol.solution_valid);
					mismatches++;
				end
				if (sol.impact_time !== want.impact_time) begin
					$error("impact_time exp %h got %h", want.impact_time, sol.impact_time);
					mismatches++;
				end
				if (sol.lead_x !== want.lead_x) begin
					$error("lead_x exp %h got %h", want.lead_x, sol.lead_x);
					mismatches++;
				end
				if (sol.lead_y !== want.lead_y) begin
					$error("lead_y exp %h got %h", want.lead_y, sol.lead_y);
					mismatches++;
				end
				if (sol.lead_z !== want.lead_z) begin
					$error("lead_z exp %h got %h", want.lead_z, sol.lead_z);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((geo_valid && !geo_stall) || (sol_valid && !sol_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		geo_valid = 1'b0;
		geo = '0;
		sol_stall = 1'b0;
		muzzle_we = 1'b0;
		muzzle_wdata = '0;
		muzzle_model = '0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		tx_idle_on = 1;
		rx_idle_on = 1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_reset_muzzle_zero();
		test_directed();
		test_random();
		test_backpressure();
		write_muzzle('0);
		test_reset_muzzle_zero();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_solutions.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/ifs_pkg.sv
rtl/ifs_sqrt.sv
rtl/ifs_div.sv
rtl/intercept_firing_solution.sv
tb/intercept_firing_solution_tb.sv
